// ----- design/vogel_pkg.sv -----
// Shared types and constants of the Vogel transportation allocation core.
package vogel_pkg;

    // Fixed field widths of the interface and the limit on results per solve.
    localparam int IDX_BITS   = 4;
    localparam int VAL_BITS   = 16;
    localparam int COST_BITS  = 16;
    localparam int SUM_BITS   = 36;
    localparam int CFG_BITS   = 5;
    localparam int OUT_MAX    = 32;

    // Default parameter values.
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_QTY_BITS = 16;

    // Input commands.
    localparam logic [1:0] CMD_COST   = 2'd0;
    localparam logic [1:0] CMD_SUPPLY = 2'd1;
    localparam logic [1:0] CMD_DEMAND = 2'd2;
    localparam logic [1:0] CMD_SOLVE  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Largest total cost; the running sum saturates here.
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef struct packed {
        logic [1:0]          cmd;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [VAL_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic [IDX_BITS-1:0] alloc_row;
        logic [IDX_BITS-1:0] alloc_col;
        logic [VAL_BITS-1:0] units;
        logic [SUM_BITS-1:0] total_cost;
        logic                is_total;
        logic                last;
    } t_out;

endpackage

// ----- design/vogel_transport_allocation_core.sv -----
// Vogel approximation transportation solver: loads, sequencer, cost memory and output stage.
// Load transfers (cost, supply, demand) are accepted back to back while the core is idle.
// Each penalty round scans every open line over the single cost memory read port, stepping
// through S_SCAN_A and S_SCAN_D per open cell; each allocation passes S_SHIP_RD, S_SHIP_MUL, S_SHIP_ACC.
// Results leave through one output register; the input stalls until the total is loaded.
// Reset (synchronous, active low) clears control state and sets both line counts to 16.
module vogel_transport_allocation_core #(
    parameter int MAX_ROWS = vogel_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = vogel_pkg::DEF_MAX_COLS,
    parameter int QTY_BITS = vogel_pkg::DEF_QTY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  vogel_pkg::t_in                  i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output vogel_pkg::t_out                 o_out,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [vogel_pkg::CFG_BITS-1:0]  i_cfg_data
);

    localparam int RW        = $clog2(MAX_ROWS);
    localparam int CW        = $clog2(MAX_COLS);
    localparam int MAX_LINES = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int LW        = $clog2(MAX_LINES + 1);
    localparam int MEM_DEPTH = 1 << (RW + CW);
    localparam int PROD_BITS = QTY_BITS + vogel_pkg::COST_BITS;
    localparam int EW        = $clog2(vogel_pkg::OUT_MAX);

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_WALK, S_SHIP_RD, S_SHIP_MUL, S_SHIP_ACC,
        S_LINE, S_SCAN_A, S_SCAN_D, S_LEND, S_TOTAL
    } t_state;

    typedef enum logic [1:0] {M_VOGEL, M_ROW, M_COL} t_mode;

    t_state r_state;
    t_mode  r_mode;

    logic [vogel_pkg::CFG_BITS-1:0] r_rows_cfg, r_cols_cfg;

    // Stores and working registers.
    logic [vogel_pkg::COST_BITS-1:0] r_mem [MEM_DEPTH];
    logic [vogel_pkg::COST_BITS-1:0] r_rd;
    logic [QTY_BITS-1:0] r_sup [MAX_ROWS];
    logic [QTY_BITS-1:0] r_dem [MAX_COLS];
    logic [QTY_BITS-1:0] r_sl  [MAX_ROWS];
    logic [QTY_BITS-1:0] r_dl  [MAX_COLS];
    logic [MAX_ROWS-1:0] r_rclosed;
    logic [MAX_COLS-1:0] r_cclosed;
    logic [vogel_pkg::SUM_BITS-1:0] r_sum;
    logic [PROD_BITS-1:0] r_prod;
    logic [EW-1:0] r_emit_cnt;

    // Sequencer registers.
    logic [LW-1:0] r_k, r_line;
    logic          r_is_row;
    logic [RW-1:0] r_ship_row;
    logic [CW-1:0] r_ship_col;
    logic [vogel_pkg::COST_BITS-1:0] r_m1, r_m2, r_best;
    logic [LW-1:0] r_pick, r_best_pick, r_best_idx;
    logic [1:0]    r_cnt;
    logic          r_have, r_best_row;

    logic            r_out_valid;
    vogel_pkg::t_out r_out;

    // Clamped line counts.
    logic [LW-1:0] lines_r, lines_c;
    always_comb begin
        if (r_rows_cfg == '0) lines_r = LW'(1);
        else if (32'(r_rows_cfg) > MAX_ROWS) lines_r = LW'(MAX_ROWS);
        else lines_r = LW'(r_rows_cfg);
        if (r_cols_cfg == '0) lines_c = LW'(1);
        else if (32'(r_cols_cfg) > MAX_COLS) lines_c = LW'(MAX_COLS);
        else lines_c = LW'(r_cols_cfg);
    end

    // Open line counts, saturating at two, with the highest open index.
    logic [1:0]    open_r, open_c;
    logic [RW-1:0] last_r;
    logic [CW-1:0] last_c;
    always_comb begin
        open_r = '0;
        open_c = '0;
        last_r = '0;
        last_c = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            if (LW'(i) < lines_r && !r_rclosed[i]) begin
                if (open_r != 2'd2) open_r = open_r + 2'd1;
                last_r = RW'(i);
            end
        end
        for (int j = 0; j < MAX_COLS; j++) begin
            if (LW'(j) < lines_c && !r_cclosed[j]) begin
                if (open_c != 2'd2) open_c = open_c + 2'd1;
                last_c = CW'(j);
            end
        end
    end

    // Handshake helpers.
    logic in_xfer, out_free;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The output register takes the total, or an allocation while fewer than OUT_MAX - 1 were sent, when it is free.
    logic load_alloc, load_out;
    assign load_alloc = (r_state == S_SHIP_MUL) && out_free &&
                        (32'(r_emit_cnt) < vogel_pkg::OUT_MAX - 1);
    assign load_out   = load_alloc || (r_state == S_TOTAL && out_free);

    // Scan geometry for the current line.
    logic [LW-1:0] scan_len, line_cnt;
    logic          other_closed, line_closed;
    assign scan_len     = r_is_row ? lines_c : lines_r;
    assign line_cnt     = r_is_row ? lines_r : lines_c;
    assign other_closed = r_is_row ? r_cclosed[r_k[CW-1:0]] : r_rclosed[r_k[RW-1:0]];
    assign line_closed  = r_is_row ? r_rclosed[r_line[RW-1:0]] : r_cclosed[r_line[CW-1:0]];

    // Walk geometry for the single-line fill.
    logic [LW-1:0] walk_len;
    logic          walk_closed;
    assign walk_len    = (r_mode == M_ROW) ? lines_c : lines_r;
    assign walk_closed = (r_mode == M_ROW) ? r_cclosed[r_k[CW-1:0]] : r_rclosed[r_k[RW-1:0]];

    // Cost memory read address.
    logic [RW+CW-1:0] rd_addr;
    always_comb begin
        if (r_state == S_SCAN_A) begin
            rd_addr = r_is_row ? {r_line[RW-1:0], r_k[CW-1:0]} : {r_k[RW-1:0], r_line[CW-1:0]};
        end else begin
            rd_addr = {r_ship_row, r_ship_col};
        end
    end

    // Units of the current allocation.
    logic [QTY_BITS-1:0] cur_s, cur_d, units;
    assign cur_s = r_sl[r_ship_row];
    assign cur_d = r_dl[r_ship_col];
    assign units = (cur_s < cur_d) ? cur_s : cur_d;

    // Penalty of the finished line.
    logic [vogel_pkg::COST_BITS-1:0] penalty;
    assign penalty = (r_cnt == 2'd2) ? (r_m2 - r_m1) : '0;

    // Saturating accumulation.
    logic [PROD_BITS:0] sum_ext;
    logic [vogel_pkg::SUM_BITS:0] sum_add;
    assign sum_ext = {1'b0, r_prod};
    assign sum_add = {1'b0, r_sum} + (vogel_pkg::SUM_BITS+1)'(sum_ext);

    // Cost memory: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.cmd == vogel_pkg::CMD_COST &&
            32'(i_in.row) < MAX_ROWS && 32'(i_in.col) < MAX_COLS) begin
            r_mem[{RW'(i_in.row), CW'(i_in.col)}] <= i_in.value;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Supply and demand stores.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.cmd == vogel_pkg::CMD_SUPPLY && 32'(i_in.row) < MAX_ROWS) begin
            r_sup[RW'(i_in.row)] <= QTY_BITS'(i_in.value);
        end
        if (in_xfer && i_in.cmd == vogel_pkg::CMD_DEMAND && 32'(i_in.col) < MAX_COLS) begin
            r_dem[CW'(i_in.col)] <= QTY_BITS'(i_in.value);
        end
    end

    // Sequencer, working registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_VOGEL;
            r_rows_cfg  <= vogel_pkg::CFG_BITS'(16);
            r_cols_cfg  <= vogel_pkg::CFG_BITS'(16);
            r_rclosed   <= '0;
            r_cclosed   <= '0;
            r_sum       <= '0;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_ROWS; i++) r_sl[i] <= '0;
            for (int j = 0; j < MAX_COLS; j++) r_dl[j] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == vogel_pkg::CFG_ROWS) r_rows_cfg <= i_cfg_data;
                else r_cols_cfg <= i_cfg_data;
            end
            if (load_out) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    // A solve reloads the working copies.
                    if (in_xfer && i_in.cmd == vogel_pkg::CMD_SOLVE) begin
                        for (int i = 0; i < MAX_ROWS; i++) r_sl[i] <= r_sup[i];
                        for (int j = 0; j < MAX_COLS; j++) r_dl[j] <= r_dem[j];
                        r_rclosed  <= '0;
                        r_cclosed  <= '0;
                        r_sum      <= '0;
                        r_emit_cnt <= '0;
                        r_state    <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_k <= '0;
                    if (open_r == 2'd0 || open_c == 2'd0) begin
                        r_state <= S_TOTAL;
                    end else if (open_r == 2'd1) begin
                        r_mode     <= M_ROW;
                        r_ship_row <= last_r;
                        r_state    <= S_WALK;
                    end else if (open_c == 2'd1) begin
                        r_mode     <= M_COL;
                        r_ship_col <= last_c;
                        r_state    <= S_WALK;
                    end else begin
                        r_mode   <= M_VOGEL;
                        r_is_row <= 1'b1;
                        r_line   <= '0;
                        r_have   <= 1'b0;
                        r_state  <= S_LINE;
                    end
                end
                S_WALK: begin
                    // Fill each open cell of the last open line in index order.
                    if (r_k == walk_len) begin
                        if (r_mode == M_ROW) r_rclosed[r_ship_row] <= 1'b1;
                        else r_cclosed[r_ship_col] <= 1'b1;
                        r_state <= S_EVAL;
                    end else begin
                        r_k <= r_k + LW'(1);
                        if (!walk_closed) begin
                            if (r_mode == M_ROW) r_ship_col <= r_k[CW-1:0];
                            else r_ship_row <= r_k[RW-1:0];
                            r_state <= S_SHIP_RD;
                        end
                    end
                end
                S_SHIP_RD: begin
                    r_state <= S_SHIP_MUL;
                end
                S_SHIP_MUL: begin
                    // Book the allocation once the output register is free.
                    if (out_free) begin
                        r_sl[r_ship_row] <= cur_s - units;
                        r_dl[r_ship_col] <= cur_d - units;
                        r_prod <= PROD_BITS'(units) * PROD_BITS'(r_rd);
                        if (r_mode != M_ROW && cur_s == units) r_rclosed[r_ship_row] <= 1'b1;
                        if (r_mode != M_COL && cur_d == units) r_cclosed[r_ship_col] <= 1'b1;
                        if (load_alloc) begin
                            r_emit_cnt            <= r_emit_cnt + EW'(1);
                            r_out.alloc_row       <= vogel_pkg::IDX_BITS'(r_ship_row);
                            r_out.alloc_col       <= vogel_pkg::IDX_BITS'(r_ship_col);
                            r_out.units           <= vogel_pkg::VAL_BITS'(units);
                            r_out.total_cost      <= '0;
                            r_out.is_total        <= 1'b0;
                            r_out.last            <= 1'b0;
                        end
                        r_state <= S_SHIP_ACC;
                    end
                end
                S_SHIP_ACC: begin
                    if (sum_add > {1'b0, vogel_pkg::SUM_MAX}) r_sum <= vogel_pkg::SUM_MAX;
                    else r_sum <= sum_add[vogel_pkg::SUM_BITS-1:0];
                    r_state <= (r_mode == M_VOGEL) ? S_EVAL : S_WALK;
                end
                S_LINE: begin
                    // Step over the open rows, then the open columns.
                    if (r_line == line_cnt) begin
                        if (r_is_row) begin
                            r_is_row <= 1'b0;
                            r_line   <= '0;
                        end else begin
                            r_ship_row <= r_best_row ? r_best_idx[RW-1:0] : r_best_pick[RW-1:0];
                            r_ship_col <= r_best_row ? r_best_pick[CW-1:0] : r_best_idx[CW-1:0];
                            r_state    <= S_SHIP_RD;
                        end
                    end else if (line_closed) begin
                        r_line <= r_line + LW'(1);
                    end else begin
                        r_k     <= '0;
                        r_cnt   <= '0;
                        r_m1    <= '0;
                        r_m2    <= '0;
                        r_pick  <= '0;
                        r_state <= S_SCAN_A;
                    end
                end
                S_SCAN_A: begin
                    if (r_k == scan_len) begin
                        r_state <= S_LEND;
                    end else if (other_closed) begin
                        r_k <= r_k + LW'(1);
                    end else begin
                        r_state <= S_SCAN_D;
                    end
                end
                S_SCAN_D: begin
                    // Track least and second-least open cost of the line.
                    if (r_cnt == 2'd0 || r_rd < r_m1) begin
                        r_m2   <= r_m1;
                        r_m1   <= r_rd;
                        r_pick <= r_k;
                    end else if (r_cnt == 2'd1 || r_rd < r_m2) begin
                        r_m2 <= r_rd;
                    end
                    if (r_cnt != 2'd2) r_cnt <= r_cnt + 2'd1;
                    r_k     <= r_k + LW'(1);
                    r_state <= S_SCAN_A;
                end
                S_LEND: begin
                    if (!r_have || penalty > r_best) begin
                        r_have      <= 1'b1;
                        r_best      <= penalty;
                        r_best_idx  <= r_line;
                        r_best_row  <= r_is_row;
                        r_best_pick <= r_pick;
                    end
                    r_line  <= r_line + LW'(1);
                    r_state <= S_LINE;
                end
                S_TOTAL: begin
                    if (out_free) begin
                        r_out.alloc_row  <= '0;
                        r_out.alloc_col  <= '0;
                        r_out.units      <= '0;
                        r_out.total_cost <= r_sum;
                        r_out.is_total   <= 1'b1;
                        r_out.last       <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The input opens again only with the total loaded into the output register.
    a_total_on_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> (o_out_valid && o_out.last && o_out.is_total))
        else $error("input opened without the total result pending");

    // The total result carries no units.
    a_total_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.is_total) |-> (o_out.units == '0))
        else $error("total result carries units");

    // An allocation is only booked while the output register can take it.
    a_ship_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIP_MUL && r_out_valid && i_out_stall) |=> (r_state == S_SHIP_MUL))
        else $error("allocation booked over a stalled result");

endmodule
